>>> hdl/tsct_pkg.sv
// Package for the connection table: command, status, reply, segment type and state codes,
// and the packed input and result word types. No dependencies.
`timescale 1ns / 1ps
package tsct_pkg;
    localparam logic [2:0] CMD_OPEN    = 3'd0;
    localparam logic [2:0] CMD_LISTEN  = 3'd1;
    localparam logic [2:0] CMD_SEGMENT = 3'd2;
    localparam logic [2:0] CMD_CONSUME = 3'd3;
    localparam logic [2:0] CMD_RELEASE = 3'd4;
    localparam logic [2:0] CMD_TICK    = 3'd5;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_FULL    = 3'd1;
    localparam logic [2:0] STS_NO_DEST = 3'd2;
    localparam logic [2:0] STS_SHORT   = 3'd3;
    localparam logic [2:0] STS_OPEN    = 3'd4;

    localparam logic [1:0] RPL_NONE    = 2'd0;
    localparam logic [1:0] RPL_SYNACK  = 2'd1;
    localparam logic [1:0] RPL_FINACK  = 2'd2;
    localparam logic [1:0] RPL_DATAACK = 2'd3;

    localparam logic [1:0] SEG_SYN   = 2'd0;
    localparam logic [1:0] SEG_DATA  = 2'd1;
    localparam logic [1:0] SEG_FIN   = 2'd2;
    localparam logic [1:0] SEG_OTHER = 2'd3;

    localparam logic [1:0] CS_CLOSED = 2'd0;
    localparam logic [1:0] CS_LISTEN = 2'd1;
    localparam logic [1:0] CS_CONN   = 2'd2;
    localparam logic [1:0] CS_CWAIT  = 2'd3;

    typedef struct packed {
        logic [2:0]  command;
        logic [2:0]  socket;
        logic [15:0] port;
        logic [15:0] client_port;
        logic [7:0]  src_node;
        logic [1:0]  seg_type;
        logic [31:0] seq_num;
        logic [12:0] amount;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [1:0]  reply_type;
        logic [7:0]  reply_node;
        logic [15:0] reply_dst_port;
        logic [15:0] reply_src_port;
        logic [31:0] ack_number;
    } out_word_t;
endpackage

>>> hdl/tsct_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module tsct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/transport_server_connection_table_core.sv
// Connection table top level: control sequencer over one entry RAM.
// Depends on tsct_pkg and tsct_ram.
`timescale 1ns / 1ps
// Sequence: open and unused commands go from scan straight to done; listen,
// consume and release read their slot in scan, then eval and done; tick walks
// every slot in scan; segment walks the slots to the first match, then eval.
// Throughput: one word at a time; busy holds through the done cycle, so a new
// word is taken only after the last result, with the scan pace set by the
// single read port of the entry RAM walked one slot per cycle.
// Reset: all slots invalid, close_wait_ticks = 1. The receiver cannot stall:
// done pulses for one cycle with the result word.
module transport_server_connection_table_core #(
    parameter int SLOTS     = 8,
    parameter int BUF_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tsct_pkg::in_word_t  cmd_in,
    output logic                busy,
    output logic                done,
    output tsct_pkg::out_word_t result,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RD = (SLOTS > 1) ? SLOTS : 2;
    localparam int EW = 2 + 16 + 16 + 8 + 32 + 13 + 16;
    localparam int CW = $clog2(SLOTS + 1);

    // entry layout: state, local, peer port, peer node, exp seq, buffered, countdown
    typedef struct packed {
        logic [1:0]  st;
        logic [15:0] lport;
        logic [15:0] pport;
        logic [7:0]  pnode;
        logic [31:0] eseq;
        logic [12:0] buf_b;
        logic [15:0] cdown;
    } entry_t;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;  // issue reads, one slot a cycle
    localparam logic [2:0] S_EVAL = 3'd2;  // single-slot modify and write back
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0]  fsm_reg, fsm_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [15:0] cwt_reg;
    tsct_pkg::in_word_t  cmd_reg;
    tsct_pkg::out_word_t res_reg, res_next;
    logic [CW-1:0] idx_reg, idx_next;     // read issue pointer
    logic [CW-1:0] ridx_reg;              // index of data now on rdata
    logic          rv_reg;                // rdata valid for ridx
    logic [AW-1:0] hit_reg, hit_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata;
    logic [EW-1:0] rbits;

    assign rdata = entry_t'(rbits);

    tsct_ram #(.WIDTH(EW), .DEPTH(RD)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(EW'(wdata)),
        .raddr(raddr), .rdata(rbits)
    );

    logic [AW-1:0] sock_a;
    logic          sock_ok;
    logic [AW-1:0] free_idx;
    logic          free_any;
    logic [31:0]   room;

    assign sock_a  = AW'(cmd_reg.socket);
    assign sock_ok = (int'(cmd_reg.socket) < SLOTS) && valid_reg[sock_a];
    assign busy    = (fsm_reg != S_IDLE);
    assign done    = (fsm_reg == S_DONE);
    assign result  = res_reg;
    assign room    = 32'(BUF_BYTES) - 32'(rdata.buf_b);

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (!valid_reg[k])
            begin
                free_any = 1'b1;
                free_idx = AW'(k);
            end
        end
    end

    // build a reply from the entry being written back
    function automatic tsct_pkg::out_word_t mk_reply(input tsct_pkg::out_word_t r,
                                                      input entry_t e,
                                                      input logic [1:0] t);
        tsct_pkg::out_word_t o;
        o = r;
        o.reply_type     = t;
        o.reply_node     = e.pnode;
        o.reply_dst_port = e.pport;
        o.reply_src_port = e.lport;
        o.ack_number     = (t == tsct_pkg::RPL_DATAACK) ? e.eseq : 32'd0;
        return o;
    endfunction

    always_comb
    begin
        entry_t e;
        fsm_next   = fsm_reg;
        valid_next = valid_reg;
        res_next   = res_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        we         = 1'b0;
        waddr      = hit_reg;
        wdata      = rdata;
        raddr      = idx_reg[AW-1:0];
        e          = rdata;
        case (fsm_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    fsm_next = S_SCAN;
                    idx_next = '0;
                    res_next = '0;
                end
            end
            S_SCAN:
            begin
                case (cmd_reg.command)
                    tsct_pkg::CMD_OPEN:
                    begin
                        // no read needed: write the fresh entry
                        if (!free_any)
                        begin
                            res_next.status = tsct_pkg::STS_FULL;
                        end
                        else
                        begin
                            we = 1'b1;
                            waddr = free_idx;
                            wdata = '{st: tsct_pkg::CS_CLOSED, lport: cmd_reg.port,
                                      pport: 16'd0, pnode: 8'hFF, eseq: 32'd0,
                                      buf_b: 13'd0, cdown: 16'd0};
                            valid_next[free_idx] = 1'b1;
                            res_next.slot = 3'(free_idx);
                        end
                        fsm_next = S_DONE;
                    end
                    tsct_pkg::CMD_LISTEN, tsct_pkg::CMD_CONSUME, tsct_pkg::CMD_RELEASE:
                    begin
                        if (!sock_ok)
                        begin
                            res_next.status = tsct_pkg::STS_NO_DEST;
                            fsm_next = S_DONE;
                        end
                        else
                        begin
                            raddr = sock_a;
                            hit_next = sock_a;
                            res_next.slot = cmd_reg.socket;
                            fsm_next = S_EVAL;
                        end
                    end
                    tsct_pkg::CMD_SEGMENT, tsct_pkg::CMD_TICK:
                    begin
                        // pipeline: issue read idx, inspect ridx
                        if (rv_reg && valid_reg[ridx_reg[AW-1:0]])
                        begin
                            if (cmd_reg.command == tsct_pkg::CMD_SEGMENT)
                            begin
                                if (rdata.lport == cmd_reg.port)
                                begin
                                    hit_next = ridx_reg[AW-1:0];
                                    fsm_next = S_EVAL;
                                end
                            end
                            else if (rdata.st == tsct_pkg::CS_CWAIT)
                            begin
                                we = 1'b1;
                                waddr = ridx_reg[AW-1:0];
                                if (rdata.cdown != 16'd0)
                                begin
                                    e.cdown = rdata.cdown - 16'd1;
                                end
                                if (e.cdown == 16'd0)
                                begin
                                    e.st = tsct_pkg::CS_CLOSED;
                                end
                                wdata = e;
                            end
                        end
                        if (fsm_next == S_SCAN)
                        begin
                            if (idx_reg == CW'(SLOTS))
                            begin
                                if (!rv_reg || ridx_reg == CW'(SLOTS - 1))
                                begin
                                    if (cmd_reg.command == tsct_pkg::CMD_SEGMENT)
                                    begin
                                        res_next.status = tsct_pkg::STS_NO_DEST;
                                    end
                                    fsm_next = S_DONE;
                                end
                            end
                            else
                            begin
                                idx_next = idx_reg + CW'(1);
                            end
                        end
                        if (fsm_next == S_EVAL)
                        begin
                            raddr = hit_next;  // re-read the hit slot for the evaluation cycle
                        end
                    end
                    default:
                    begin
                        fsm_next = S_DONE;
                    end
                endcase
            end
            S_EVAL:
            begin
                fsm_next = S_DONE;
                res_next.slot = 3'(hit_reg);
                case (cmd_reg.command)
                    tsct_pkg::CMD_LISTEN:
                    begin
                        we = 1'b1;
                        e.st = tsct_pkg::CS_LISTEN;
                        wdata = e;
                    end
                    tsct_pkg::CMD_CONSUME:
                    begin
                        if (cmd_reg.amount <= rdata.buf_b)
                        begin
                            we = 1'b1;
                            e.buf_b = rdata.buf_b - cmd_reg.amount;
                            wdata = e;
                        end
                        else
                        begin
                            res_next.status = tsct_pkg::STS_SHORT;
                        end
                    end
                    tsct_pkg::CMD_RELEASE:
                    begin
                        if (rdata.st != tsct_pkg::CS_CLOSED)
                        begin
                            res_next.status = tsct_pkg::STS_OPEN;
                        end
                        else
                        begin
                            valid_next[hit_reg] = 1'b0;
                        end
                    end
                    default:
                    begin
                        // segment dispatch on the matched slot
                        case (rdata.st)
                            tsct_pkg::CS_LISTEN:
                            begin
                                if (cmd_reg.seg_type == tsct_pkg::SEG_SYN)
                                begin
                                    e.st = tsct_pkg::CS_CONN;
                                    e.pport = cmd_reg.client_port;
                                    e.pnode = cmd_reg.src_node;
                                    we = 1'b1;
                                    res_next = mk_reply(res_next, e, tsct_pkg::RPL_SYNACK);
                                end
                            end
                            tsct_pkg::CS_CONN:
                            begin
                                if (cmd_reg.client_port == rdata.pport)
                                begin
                                    if (cmd_reg.seg_type == tsct_pkg::SEG_SYN)
                                    begin
                                        e.eseq = cmd_reg.seq_num;
                                        we = 1'b1;
                                        res_next = mk_reply(res_next, e,
                                                            tsct_pkg::RPL_SYNACK);
                                    end
                                    else if (cmd_reg.seg_type == tsct_pkg::SEG_DATA)
                                    begin
                                        if (cmd_reg.seq_num != rdata.eseq)
                                        begin
                                            res_next = mk_reply(res_next, e,
                                                                tsct_pkg::RPL_DATAACK);
                                        end
                                        else if (room >= 32'(cmd_reg.amount))
                                        begin
                                            e.buf_b = rdata.buf_b + cmd_reg.amount;
                                            e.eseq = rdata.eseq + 32'(cmd_reg.amount);
                                            we = 1'b1;
                                            res_next = mk_reply(res_next, e,
                                                                tsct_pkg::RPL_DATAACK);
                                        end
                                    end
                                    else if (cmd_reg.seg_type == tsct_pkg::SEG_FIN)
                                    begin
                                        e.st = tsct_pkg::CS_CWAIT;
                                        e.cdown = cwt_reg;
                                        we = 1'b1;
                                        res_next = mk_reply(res_next, e,
                                                            tsct_pkg::RPL_FINACK);
                                    end
                                end
                            end
                            tsct_pkg::CS_CWAIT:
                            begin
                                if (cmd_reg.client_port == rdata.pport &&
                                    cmd_reg.seg_type == tsct_pkg::SEG_FIN)
                                begin
                                    e.cdown = cwt_reg;
                                    we = 1'b1;
                                    res_next = mk_reply(res_next, e, tsct_pkg::RPL_FINACK);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        wdata = e;
                    end
                endcase
            end
            S_DONE:
            begin
                fsm_next = S_IDLE;
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg   <= S_IDLE;
            valid_reg <= '0;
            cwt_reg   <= 16'd1;
            idx_reg   <= '0;
            ridx_reg  <= '0;
            rv_reg    <= 1'b0;
            hit_reg   <= '0;
        end
        else
        begin
            fsm_reg   <= fsm_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
            // read data tracks the address issued this cycle during a scan
            rv_reg    <= (fsm_reg == S_SCAN) && (fsm_next == S_SCAN) &&
                         (idx_reg != CW'(SLOTS));
            ridx_reg  <= idx_reg;
            if (cfg_we)
            begin
                cwt_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fsm_reg == S_IDLE && start)
        begin
            cmd_reg <= cmd_in;
        end
        res_reg <= res_next;
    end

    // a result strobe always follows a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("done without busy");
    // done is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    // no entry written while idle
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == S_IDLE) |-> !we) else $error("RAM write while idle");
endmodule

>>> tb/transport_server_connection_table_core_test.sv
// Self-checking bench for the connection table core: drives command words,
// predicts each result word with a behavioural table model and compares them.
// Depends on tsct_pkg and the transport_server_connection_table_core RTL.
`timescale 1ns / 1ps

// Behavioural copy of the table plus the queue of result words still owed.
class conn_table_scoreboard;
    localparam int NSLOT = 8;
    localparam int BUFSZ = 4096;

    bit          valid [NSLOT];
    logic [1:0]  cstate [NSLOT];
    logic [15:0] lport [NSLOT];
    logic [15:0] pport [NSLOT];
    logic [7:0]  pnode [NSLOT];
    logic [31:0] xseq [NSLOT];
    logic [12:0] held [NSLOT];
    logic [15:0] cdown [NSLOT];
    logic [15:0] wait_ticks;
    tsct_pkg::out_word_t owed [$];
    int errors;

    function new();
        wait_ticks = 16'd1;
        errors = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            valid[i] = 0; cstate[i] = tsct_pkg::CS_CLOSED; lport[i] = '0;
            pport[i] = '0; pnode[i] = '0; xseq[i] = '0; held[i] = '0; cdown[i] = '0;
        end
    endfunction

    function void reply(inout tsct_pkg::out_word_t r, input int s, input logic [1:0] k);
        r.reply_type     = k;
        r.reply_node     = pnode[s];
        r.reply_dst_port = pport[s];
        r.reply_src_port = lport[s];
        r.ack_number     = (k == tsct_pkg::RPL_DATAACK) ? xseq[s] : '0;
    endfunction

    // Advance the table by one accepted command word and queue its result.
    function void note_command(tsct_pkg::in_word_t w);
        tsct_pkg::out_word_t r;
        int i;
        bit ok;
        r = '0;
        ok = valid[w.socket];
        case (w.command)
            tsct_pkg::CMD_OPEN:
            begin
                for (i = 0; i < NSLOT; i++) if (!valid[i]) break;
                if (i == NSLOT) r.status = tsct_pkg::STS_FULL;
                else
                begin
                    valid[i] = 1; cstate[i] = tsct_pkg::CS_CLOSED; lport[i] = w.port;
                    pport[i] = '0; pnode[i] = 8'hFF; xseq[i] = '0; held[i] = '0;
                    cdown[i] = '0; r.slot = 3'(i);
                end
            end
            tsct_pkg::CMD_LISTEN:
                if (!ok) r.status = tsct_pkg::STS_NO_DEST;
                else
                begin
                    cstate[w.socket] = tsct_pkg::CS_LISTEN; r.slot = w.socket;
                end
            tsct_pkg::CMD_SEGMENT:
            begin
                for (i = 0; i < NSLOT; i++) if (valid[i] && lport[i] == w.port) break;
                if (i == NSLOT) r.status = tsct_pkg::STS_NO_DEST;
                else
                begin
                    r.slot = 3'(i);
                    case (cstate[i])
                        tsct_pkg::CS_LISTEN:
                            if (w.seg_type == tsct_pkg::SEG_SYN)
                            begin
                                cstate[i] = tsct_pkg::CS_CONN; pport[i] = w.client_port;
                                pnode[i] = w.src_node; reply(r, i, tsct_pkg::RPL_SYNACK);
                            end
                        tsct_pkg::CS_CONN:
                            if (w.client_port == pport[i])
                            begin
                                if (w.seg_type == tsct_pkg::SEG_SYN)
                                begin
                                    xseq[i] = w.seq_num; reply(r, i, tsct_pkg::RPL_SYNACK);
                                end
                                else if (w.seg_type == tsct_pkg::SEG_DATA)
                                begin
                                    if (w.seq_num != xseq[i]) reply(r, i, tsct_pkg::RPL_DATAACK);
                                    else if (BUFSZ - int'(held[i]) >= int'(w.amount))
                                    begin
                                        held[i] = held[i] + w.amount;
                                        xseq[i] = xseq[i] + 32'(w.amount);
                                        reply(r, i, tsct_pkg::RPL_DATAACK);
                                    end
                                end
                                else if (w.seg_type == tsct_pkg::SEG_FIN)
                                begin
                                    cstate[i] = tsct_pkg::CS_CWAIT; cdown[i] = wait_ticks;
                                    reply(r, i, tsct_pkg::RPL_FINACK);
                                end
                            end
                        tsct_pkg::CS_CWAIT:
                            if (w.client_port == pport[i] && w.seg_type == tsct_pkg::SEG_FIN)
                            begin
                                cdown[i] = wait_ticks; reply(r, i, tsct_pkg::RPL_FINACK);
                            end
                        default: ;
                    endcase
                end
            end
            tsct_pkg::CMD_CONSUME:
                if (!ok) r.status = tsct_pkg::STS_NO_DEST;
                else
                begin
                    r.slot = w.socket;
                    if (w.amount <= held[w.socket]) held[w.socket] -= w.amount;
                    else r.status = tsct_pkg::STS_SHORT;
                end
            tsct_pkg::CMD_RELEASE:
                if (!ok) r.status = tsct_pkg::STS_NO_DEST;
                else
                begin
                    r.slot = w.socket;
                    if (cstate[w.socket] != tsct_pkg::CS_CLOSED) r.status = tsct_pkg::STS_OPEN;
                    else valid[w.socket] = 0;
                end
            tsct_pkg::CMD_TICK:
                for (int s = 0; s < NSLOT; s++)
                    if (valid[s] && cstate[s] == tsct_pkg::CS_CWAIT)
                    begin
                        if (cdown[s] > 0) cdown[s]--;
                        if (cdown[s] == 0) cstate[s] = tsct_pkg::CS_CLOSED;
                    end
            default: ;
        endcase
        owed.push_back(r);
    endfunction

    function void check_result(tsct_pkg::out_word_t got);
        tsct_pkg::out_word_t exp;
        if (owed.size() == 0)
        begin
            $display("%0t: result with none owed, actual %h", $time, got);
            errors++;
            return;
        end
        exp = owed.pop_front();
        if (got.status !== exp.status || got.slot !== exp.slot
            || got.reply_type !== exp.reply_type || got.reply_node !== exp.reply_node
            || got.reply_dst_port !== exp.reply_dst_port
            || got.reply_src_port !== exp.reply_src_port
            || got.ack_number !== exp.ack_number)
        begin
            $display("%0t: mismatch expected %h actual %h", $time, exp, got);
            errors++;
        end
    endfunction
endclass

module transport_server_connection_table_core_test;
    localparam int CYCLE_LIMIT = 400000;

    logic                clk = 0;
    logic                rst_n = 0;
    logic                start = 0;
    tsct_pkg::in_word_t  cmd_in = '0;
    logic                busy;
    logic                done;
    tsct_pkg::out_word_t result;
    logic                cfg_we = 0;
    logic [15:0]         cfg_wdata = '0;
    int                  cycles = 0;

    conn_table_scoreboard table_model = new();

    // Port pool kept tiny so segments actually find their slots.
    logic [15:0] port_pool [4] = '{16'h0000, 16'hFFFF, 16'h1234, 16'h0050};
    logic [15:0] client_pool [2] = '{16'hFFFF, 16'h0001};

    transport_server_connection_table_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd_in(cmd_in), .busy(busy),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    // Check every result word on the edge that ends its strobe cycle.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done) table_model.check_result(result);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Present one word from a falling edge and hold it until accepted.
    task automatic issue(tsct_pkg::in_word_t w);
        bit taken;
        @(negedge clk);
        cmd_in <= w;
        start  <= 1'b1;
        taken = 0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
            if (taken) table_model.note_command(w);
            @(negedge clk);
        end
        start <= 1'b0;
    endtask

    // Drain outstanding words, let any tail finish, then write the register.
    task automatic set_wait_ticks(logic [15:0] v);
        while (table_model.owed.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        table_model.wait_ticks = v;
    endtask

    function automatic tsct_pkg::in_word_t mk(logic [2:0] c, logic [2:0] s,
                                              logic [15:0] p, logic [15:0] sp,
                                              logic [1:0] t, logic [31:0] q,
                                              logic [12:0] a);
        tsct_pkg::in_word_t w;
        w.command = c; w.socket = s; w.port = p; w.client_port = sp;
        w.src_node = 8'($urandom); w.seg_type = t; w.seq_num = q; w.amount = a;
        return w;
    endfunction

    // Mostly well-formed words aimed at live ports, with some pure noise.
    function automatic tsct_pkg::in_word_t random_word();
        tsct_pkg::in_word_t w;
        int pick;
        w = tsct_pkg::in_word_t'({$urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        w.port = port_pool[$urandom_range(0, 3)];
        w.client_port = client_pool[$urandom_range(0, 1)];
        if (w.amount > 13'd4096) w.amount = 13'($urandom_range(0, 4096));
        if (pick < 8) w.command = tsct_pkg::CMD_OPEN;
        else if (pick < 18) w.command = tsct_pkg::CMD_LISTEN;
        else if (pick < 62)
        begin
            w.command = tsct_pkg::CMD_SEGMENT;
            if ($urandom_range(0, 3) != 0)
                w.seq_num = table_model.xseq[$urandom_range(0, 7)];
            if ($urandom_range(0, 2) != 0) w.amount = 13'($urandom_range(0, 600));
        end
        else if (pick < 72) w.command = tsct_pkg::CMD_CONSUME;
        else if (pick < 80) w.command = tsct_pkg::CMD_RELEASE;
        else if (pick < 95) w.command = tsct_pkg::CMD_TICK;
        else
        begin
            w = tsct_pkg::in_word_t'({$urandom, $urandom, $urandom});
            if (w.amount > 13'd4096) w.amount = 13'd4096;
        end
        return w;
    endfunction

    initial
    begin
        int gap;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: fill the table, overflow it, release, listen, handshake, data, consume, close, tick, unused codes.
        for (int i = 0; i < 8; i++)
            issue(mk(tsct_pkg::CMD_OPEN, 3'd0, port_pool[i % 4], 16'd0,
                     tsct_pkg::SEG_SYN, 32'd0, 13'd0));
        issue(mk(tsct_pkg::CMD_OPEN, 3'd0, 16'h7777, 16'd0, tsct_pkg::SEG_SYN,
                 32'd0, 13'd0));
        issue(mk(tsct_pkg::CMD_RELEASE, 3'd7, 16'd0, 16'd0, tsct_pkg::SEG_SYN,
                 32'd0, 13'd0));
        issue(mk(tsct_pkg::CMD_LISTEN, 3'd7, 16'd0, 16'd0, tsct_pkg::SEG_SYN,
                 32'd0, 13'd0));
        issue(mk(tsct_pkg::CMD_LISTEN, 3'd0, 16'd0, 16'd0, tsct_pkg::SEG_SYN,
                 32'd0, 13'd0));
        issue(mk(tsct_pkg::CMD_SEGMENT, 3'd0, 16'h0000, 16'hFFFF, tsct_pkg::SEG_SYN,
                 32'hFFFF_FFFF, 13'd0));
        issue(mk(tsct_pkg::CMD_SEGMENT, 3'd0, 16'h0000, 16'hFFFF, tsct_pkg::SEG_SYN,
                 32'hFFFF_FFF0, 13'd0));
        issue(mk(tsct_pkg::CMD_SEGMENT, 3'd0, 16'h0000, 16'hFFFF, tsct_pkg::SEG_DATA,
                 32'hFFFF_FFF0, 13'd4096));
        issue(mk(tsct_pkg::CMD_SEGMENT, 3'd0, 16'h0000, 16'hFFFF, tsct_pkg::SEG_DATA,
                 32'h0000_0FF0, 13'd1));
        issue(mk(tsct_pkg::CMD_SEGMENT, 3'd0, 16'h0000, 16'hFFFF, tsct_pkg::SEG_DATA,
                 32'h0000_0FF0, 13'd1));
        issue(mk(tsct_pkg::CMD_SEGMENT, 3'd0, 16'h0000, 16'h0001, tsct_pkg::SEG_DATA,
                 32'd0, 13'd0));
        issue(mk(tsct_pkg::CMD_SEGMENT, 3'd0, 16'h0000, 16'hFFFF, tsct_pkg::SEG_OTHER,
                 32'd0, 13'd0));
        issue(mk(tsct_pkg::CMD_SEGMENT, 3'd0, 16'hBEEF, 16'hFFFF, tsct_pkg::SEG_SYN,
                 32'd0, 13'd0));
        issue(mk(tsct_pkg::CMD_CONSUME, 3'd0, 16'd0, 16'd0, tsct_pkg::SEG_SYN,
                 32'd0, 13'd4097));
        issue(mk(tsct_pkg::CMD_CONSUME, 3'd0, 16'd0, 16'd0, tsct_pkg::SEG_SYN,
                 32'd0, 13'd4096));
        issue(mk(tsct_pkg::CMD_SEGMENT, 3'd0, 16'h0000, 16'hFFFF, tsct_pkg::SEG_FIN,
                 32'd0, 13'd0));
        issue(mk(tsct_pkg::CMD_SEGMENT, 3'd0, 16'h0000, 16'hFFFF, tsct_pkg::SEG_FIN,
                 32'd0, 13'd0));
        issue(mk(tsct_pkg::CMD_RELEASE, 3'd0, 16'd0, 16'd0, tsct_pkg::SEG_SYN,
                 32'd0, 13'd0));
        issue(mk(tsct_pkg::CMD_TICK, 3'd0, 16'd0, 16'd0, tsct_pkg::SEG_SYN,
                 32'd0, 13'd0));
        issue(mk(3'd6, 3'd0, 16'd0, 16'd0, tsct_pkg::SEG_SYN, 32'd0, 13'd0));
        issue(mk(3'd7, 3'd0, 16'd0, 16'd0, tsct_pkg::SEG_SYN, 32'd0, 13'd0));
        issue(mk(tsct_pkg::CMD_RELEASE, 3'd0, 16'd0, 16'd0, tsct_pkg::SEG_SYN,
                 32'd0, 13'd0));

        // Random phases through several countdown settings, extremes included.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_wait_ticks(16'd0);
                1: set_wait_ticks(16'd3);
                2: set_wait_ticks(16'hFFFF);
                3: set_wait_ticks(16'($urandom_range(1, 6)));
                default: set_wait_ticks(16'd1);
            endcase
            for (int n = 0; n < 100; )
            begin
                // Burst of back-to-back words, then an idle gap that is sometimes empty.
                for (int b = $urandom_range(1, 12); b > 0 && n < 100; b--, n++)
                    issue(random_word());
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                repeat (gap) @(negedge clk);
            end
        end

        while (table_model.owed.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (table_model.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

>>> transport_server_connection_table_core.f
hdl/tsct_pkg.sv
hdl/tsct_ram.sv
hdl/transport_server_connection_table_core.sv
tb/transport_server_connection_table_core_test.sv
